>>> rtl/vftm_pkg.sv
// Package for the VLAN filter table manager.
// Holds table sizes, field widths, filter word bit positions, codes and table port structs.
// No dependencies.
package vftm_pkg;

    localparam int TBL_DEPTH = 32;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int WORD_W    = 32;
    localparam int VID_W     = 16;
    localparam int CHAN_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;

    localparam logic [VID_W-1:0] ID_MAX = 16'd4095;

    localparam int BIT_ENABLE   = 16;
    localparam int BIT_EXTENDED = 17;
    localparam int BIT_INVERSE  = 18;
    localparam int BIT_CHAN_EN  = 24;
    localparam int CHAN_SHIFT   = 25;

    localparam logic [CNT_W-1:0]  NUM_ENTRIES_RST   = 6'd32;
    localparam logic [CHAN_W-1:0] ROUTE_CHANNEL_RST = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_DEL     = 2'd1,
        OP_PRELOAD = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_BAD_ID    = 3'd2,
        ST_FULL      = 3'd3,
        ST_DELETED   = 3'd4,
        ST_PRELOADED = 3'd5,
        ST_BAD_SLOT  = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ENTRIES   = 1'b0,
        CFG_ROUTE_CHANNEL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              f_we;
        logic              o_we;
        logic              clr;
        logic [IDX_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_tbl_req;

    typedef struct packed {
        logic [WORD_W-1:0] f_q;
        logic [WORD_W-1:0] o_q;
    } t_tbl_rsp;

endpackage

>>> rtl/vftm_table.sv
// Filter and owner word memories with per-entry valid bits.
// One read port (registered data) and one write port; uses vftm_pkg.
module vftm_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vftm_pkg::t_tbl_req i_req,
    output vftm_pkg::t_tbl_rsp o_rsp
);
    import vftm_pkg::*;

    logic [WORD_W-1:0]    r_f_mem [TBL_DEPTH];
    logic [WORD_W-1:0]    r_o_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_f_valid;
    logic [TBL_DEPTH-1:0] r_o_valid;
    logic [WORD_W-1:0]    r_f_q;
    logic [WORD_W-1:0]    r_o_q;
    logic                 r_fv_q;
    logic                 r_ov_q;

    always_ff @(posedge i_clk) begin
        if (i_req.f_we) begin
            r_f_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.o_we) begin
            r_o_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_f_q <= r_f_mem[i_req.rd_addr];
        r_o_q <= r_o_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= '0;
            r_o_valid <= '0;
            r_fv_q    <= 1'b0;
            r_ov_q    <= 1'b0;
        end else begin
            r_fv_q <= r_f_valid[i_req.rd_addr];
            r_ov_q <= r_o_valid[i_req.rd_addr];
            if (i_req.f_we) begin
                r_f_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.o_we) begin
                r_o_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.clr) begin
                r_f_valid[i_req.wr_addr] <= 1'b0;
                r_o_valid[i_req.wr_addr] <= 1'b0;
            end
        end
    end

    assign o_rsp.f_q = r_fv_q ? r_f_q : '0;
    assign o_rsp.o_q = r_ov_q ? r_o_q : '0;

endmodule

>>> rtl/vftm_ctrl.sv
// Sequencer for add, delete and preload: scans the table, writes back, holds the result.
// Also holds the configuration registers; uses vftm_pkg.
module vftm_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [vftm_pkg::VID_W-1:0]       i_vlan_id,
    input  logic [vftm_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [vftm_pkg::WORD_W-1:0]      i_entry_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_status,
    output logic [vftm_pkg::IDX_W-1:0]       o_slot_used,
    output logic [vftm_pkg::CNT_W-1:0]       o_removed_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vftm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vftm_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output vftm_pkg::t_tbl_req               o_req,
    input  vftm_pkg::t_tbl_rsp               i_rsp
);
    import vftm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state;
    t_opcode            r_op;
    logic [VID_W-1:0]   r_vid;
    logic [IDX_W-1:0]   r_slot;
    logic [WORD_W-1:0]  r_entry;
    logic [WORD_W-1:0]  r_word;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_chk;
    logic               r_found;
    logic [IDX_W-1:0]   r_free;
    logic [CNT_W-1:0]   r_cnt;
    t_status            r_res_status;
    logic [IDX_W-1:0]   r_res_slot;
    logic [CNT_W-1:0]   r_res_cnt;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [IDX_W-1:0]   r_out_slot;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [CNT_W-1:0]   r_num_entries;
    logic [CHAN_W-1:0]  r_route;

    t_opcode            w_op;
    logic [CNT_W-1:0]   w_n;
    logic [WORD_W-1:0]  w_word;
    logic               w_bad_id;
    logic               w_last;
    logic               w_match;
    logic               w_free_now;
    logic               w_del_hit;
    logic [CNT_W-1:0]   n_cnt;

    assign w_op     = t_opcode'(i_opcode);
    assign w_n      = (r_num_entries > CNT_W'(TBL_DEPTH)) ? CNT_W'(TBL_DEPTH) : r_num_entries;
    assign w_bad_id = (i_vlan_id == '0) || (i_vlan_id > ID_MAX);

    always_comb begin
        w_word                = '0;
        w_word[VID_W-1:0]     = i_vlan_id;
        w_word[BIT_ENABLE]    = 1'b1;
        w_word[BIT_EXTENDED]  = 1'b1;
        w_word[BIT_INVERSE]   = 1'b1;
        w_word[BIT_CHAN_EN]   = 1'b1;
        w_word[CHAN_SHIFT +: CHAN_W] = r_route;
    end

    assign w_last     = ({1'b0, r_chk} == (r_n - CNT_W'(1)));
    assign w_match    = (i_rsp.f_q == r_word);
    assign w_free_now = !i_rsp.f_q[BIT_ENABLE];
    assign w_del_hit  = (i_rsp.f_q[VID_W-1:0] == r_vid) && (i_rsp.f_q != i_rsp.o_q);
    assign n_cnt      = w_del_hit ? r_cnt + CNT_W'(1) : r_cnt;

    always_comb begin
        o_req         = '0;
        o_req.rd_addr = r_idx[IDX_W-1:0];
        if (r_state == S_SCAN && r_pend && r_op == OP_DEL && w_del_hit) begin
            o_req.clr     = 1'b1;
            o_req.wr_addr = r_chk;
        end
        if (r_state == S_WRITE) begin
            if (r_op == OP_PRELOAD) begin
                o_req.f_we    = 1'b1;
                o_req.o_we    = 1'b1;
                o_req.wr_addr = r_slot;
                o_req.wr_data = r_entry;
            end else begin
                o_req.f_we    = 1'b1;
                o_req.wr_addr = r_free;
                o_req.wr_data = r_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_entries <= NUM_ENTRIES_RST;
            r_route       <= ROUTE_CHANNEL_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NUM_ENTRIES:   r_num_entries <= i_cfg_data[CNT_W-1:0];
                CFG_ROUTE_CHANNEL: r_route       <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op         <= w_op;
                        r_vid        <= i_vlan_id;
                        r_slot       <= i_slot_index;
                        r_entry      <= i_entry_word;
                        r_word       <= w_word;
                        r_n          <= w_n;
                        r_idx        <= '0;
                        r_pend       <= 1'b0;
                        r_found      <= 1'b0;
                        r_free       <= '0;
                        r_cnt        <= '0;
                        r_res_slot   <= '0;
                        r_res_cnt    <= '0;
                        case (w_op)
                            OP_ADD: begin
                                if (w_bad_id) begin
                                    r_res_status <= ST_BAD_ID;
                                    r_state      <= S_DONE;
                                end else if (w_n == '0) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_DEL: begin
                                if (w_n == '0) begin
                                    r_res_status <= ST_DELETED;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_PRELOAD: begin
                                if ({1'b0, i_slot_index} >= w_n) begin
                                    r_res_status <= ST_BAD_SLOT;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_WRITE;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_n) begin
                        r_idx  <= r_idx + CNT_W'(1);
                        r_pend <= 1'b1;
                        r_chk  <= r_idx[IDX_W-1:0];
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (r_op == OP_ADD) begin
                            if (w_match) begin
                                r_res_status <= ST_PRESENT;
                                r_state      <= S_DONE;
                            end else begin
                                if (w_free_now) begin
                                    r_found <= 1'b1;
                                    r_free  <= r_chk;
                                end
                                if (w_last) begin
                                    if (r_found || w_free_now) begin
                                        r_state <= S_WRITE;
                                    end else begin
                                        r_res_status <= ST_FULL;
                                        r_state      <= S_DONE;
                                    end
                                end
                            end
                        end else begin
                            r_cnt <= n_cnt;
                            if (w_last) begin
                                r_res_status <= ST_DELETED;
                                r_res_cnt    <= n_cnt;
                                r_state      <= S_DONE;
                            end
                        end
                    end
                end
                S_WRITE: begin
                    if (r_op == OP_PRELOAD) begin
                        r_res_status <= ST_PRELOADED;
                        r_res_slot   <= r_slot;
                    end else begin
                        r_res_status <= ST_ADDED;
                        r_res_slot   <= r_free;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_cnt    <= r_res_cnt;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_used     = r_out_slot;
    assign o_removed_count = r_out_cnt;

endmodule

>>> rtl/vlan_filter_table_manager.sv
// VLAN receive-filter table manager: one operation at a time over a 32-entry
// filter table and owner table. An add or delete reads one entry per cycle through the
// table's single read port; an add that finds its word present stops at that entry. A preload
// writes its slot without a scan; an invalid id, a bad slot, or an add or delete with no
// slots in use goes straight to the result.
// The result sits in an output register, so the next beat is taken while the previous result
// waits; a second finished result holds until the first is taken. Both tables read as
// zero after reset through per-entry valid bits; no clearing pass is needed.
// Top level: ties vftm_ctrl to vftm_table; uses vftm_pkg.
module vlan_filter_table_manager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [vftm_pkg::VID_W-1:0]       i_vlan_id,
    input  logic [vftm_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [vftm_pkg::WORD_W-1:0]      i_entry_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_status,
    output logic [vftm_pkg::IDX_W-1:0]       o_slot_used,
    output logic [vftm_pkg::CNT_W-1:0]       o_removed_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vftm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vftm_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import vftm_pkg::*;

    t_tbl_req w_req;
    t_tbl_rsp w_rsp;

    vftm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_vlan_id       (i_vlan_id),
        .i_slot_index    (i_slot_index),
        .i_entry_word    (i_entry_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_slot_used     (o_slot_used),
        .o_removed_count (o_removed_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_req           (w_req),
        .i_rsp           (w_rsp)
    );

    vftm_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

endmodule

>>> tb/tb_top.sv
// Testbench for vlan_filter_table_manager: a directed table of add, delete and preload beats,
// then random beats under several table sizes, route channels and idle patterns.
// Depends on rtl/vftm_pkg.sv and rtl/vlan_filter_table_manager.sv; every result is predicted here.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vftm_pkg::*;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;
    localparam int POOL_MAX        = 40;

    localparam logic [CNT_W-1:0] PHASE_NUM [8] = '{
        6'd32, 6'd8, 6'd63, 6'd1, 6'd0, 6'd33, 6'd16, 6'd3
    };
    localparam logic [CHAN_W-1:0] PHASE_ROUTE [8] = '{
        3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6, 3'd1
    };
    localparam int IDLE_PCT  [4] = '{0, 85, 0, 7};
    localparam int STALL_PCT [4] = '{0, 0, 85, 7};

    typedef struct packed {
        t_opcode           op;
        logic [VID_W-1:0]  vid;
        logic [IDX_W-1:0]  slot;
        logic [WORD_W-1:0] word;
    } t_filter_cmd;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] slot;
        logic [CNT_W-1:0] removed;
    } t_filter_resp;

    typedef struct packed {
        logic                 is_cfg;
        t_cfg_idx             reg_idx;
        logic [CFG_DAT_W-1:0] reg_data;
        t_filter_cmd          cmd;
        logic                 typed;
        t_filter_resp         resp;
    } t_dir_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_opcode        = '0;
    logic [VID_W-1:0]     i_vlan_id       = '0;
    logic [IDX_W-1:0]     i_slot_index    = '0;
    logic [WORD_W-1:0]    i_entry_word    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [2:0]           o_status;
    logic [IDX_W-1:0]     o_slot_used;
    logic [CNT_W-1:0]     o_removed_count;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;

    logic [WORD_W-1:0] filt_tbl [TBL_DEPTH];
    logic [WORD_W-1:0] own_tbl  [TBL_DEPTH];
    logic [CNT_W-1:0]  cfg_num   = NUM_ENTRIES_RST;
    logic [CHAN_W-1:0] cfg_route = ROUTE_CHANNEL_RST;
    t_filter_resp      pending_resp_q [$];
    logic [VID_W-1:0]  vid_pool [POOL_MAX];
    int                pool_len     = 2;
    int                idle_pct     = 0;
    int                stall_pct    = 0;
    int                mismatch_cnt = 0;
    int                quiet_cycles = 0;
    int                hold_left    = 0;
    logic              hold_req     = 1'b0;

    vlan_filter_table_manager i_dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] vlan_word(logic [VID_W-1:0] vid,
                                                    logic [CHAN_W-1:0] chan);
        logic [WORD_W-1:0] w;
        w = WORD_W'(vid);
        w[BIT_ENABLE]   = 1'b1;
        w[BIT_EXTENDED] = 1'b1;
        w[BIT_INVERSE]  = 1'b1;
        w[BIT_CHAN_EN]  = 1'b1;
        w[CHAN_SHIFT +: CHAN_W] = chan;
        return w;
    endfunction

    function automatic int slots_active();
        return (cfg_num > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_num);
    endfunction

    function automatic logic apply_table_op(input t_filter_cmd c, output t_filter_resp r);
        logic [WORD_W-1:0] w;
        int                n;
        int                free_slot;
        logic              found_free;
        logic              hit;
        logic [CNT_W-1:0]  cleared;
        n          = slots_active();
        r          = '0;
        found_free = 1'b0;
        hit        = 1'b0;
        free_slot  = 0;
        cleared    = '0;
        case (c.op)
            OP_ADD: begin
                if (c.vid == '0 || c.vid > ID_MAX) begin
                    r.status = ST_BAD_ID;
                end else begin
                    w = vlan_word(c.vid, cfg_route);
                    for (int i = 0; i < n; i++) begin
                        if (!hit) begin
                            if (filt_tbl[i] == w) begin
                                hit = 1'b1;
                            end else if (!filt_tbl[i][BIT_ENABLE]) begin
                                found_free = 1'b1;
                                free_slot  = i;
                            end
                        end
                    end
                    if (hit) begin
                        r.status = ST_PRESENT;
                    end else if (!found_free) begin
                        r.status = ST_FULL;
                    end else begin
                        filt_tbl[free_slot] = w;
                        r.status = ST_ADDED;
                        r.slot   = IDX_W'(free_slot);
                    end
                end
            end
            OP_DEL: begin
                for (int i = 0; i < n; i++) begin
                    if (filt_tbl[i][VID_W-1:0] == c.vid && filt_tbl[i] != own_tbl[i]) begin
                        filt_tbl[i] = '0;
                        own_tbl[i]  = '0;
                        cleared++;
                    end
                end
                r.status  = ST_DELETED;
                r.removed = cleared;
            end
            OP_PRELOAD: begin
                if (int'(c.slot) >= n) begin
                    r.status = ST_BAD_SLOT;
                end else begin
                    filt_tbl[c.slot] = c.word;
                    own_tbl[c.slot]  = c.word;
                    r.status = ST_PRELOADED;
                    r.slot   = c.slot;
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_dir_row cmd_row(t_opcode op, logic [VID_W-1:0] vid,
                                         logic [IDX_W-1:0] slot, logic [WORD_W-1:0] word,
                                         logic typed = 1'b0, t_status st = ST_ADDED,
                                         logic [IDX_W-1:0] sl = '0,
                                         logic [CNT_W-1:0] rm = '0);
        t_dir_row r;
        r             = '0;
        r.cmd.op      = op;
        r.cmd.vid     = vid;
        r.cmd.slot    = slot;
        r.cmd.word    = word;
        r.typed       = typed;
        r.resp.status = st;
        r.resp.slot   = sl;
        r.resp.removed = rm;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        t_dir_row r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_filter_cmd draw_cmd();
        t_filter_cmd c;
        int          pick;
        int          n;
        int          kind;
        n      = slots_active();
        pick   = $urandom_range(99);
        c.op   = OP_ADD;
        c.vid  = VID_W'($urandom);
        c.slot = IDX_W'($urandom);
        c.word = $urandom;
        if (pick < 40) begin
            c.vid = vid_pool[$urandom_range(pool_len - 1)];
        end else if (pick < 60) begin
            c.op  = OP_DEL;
            c.vid = vid_pool[$urandom_range(pool_len - 1)];
        end else if (pick < 65) begin
            c.op = OP_DEL;
        end else if (pick < 80) begin
            c.op = OP_PRELOAD;
            if (n > 0 && $urandom_range(99) < 75) begin
                c.slot = IDX_W'($urandom_range(n - 1));
            end
            kind = $urandom_range(2);
            if (kind == 0) begin
                c.word = vlan_word(vid_pool[$urandom_range(pool_len - 1)],
                                   ($urandom_range(99) < 70) ? cfg_route : CHAN_W'($urandom));
            end else if (kind == 1) begin
                c.word[BIT_ENABLE] = 1'b0;
            end
        end else if (pick < 90) begin
            c.vid = ($urandom_range(1) == 0) ? '0 : VID_W'($urandom_range(65535, 4096));
        end else if (pick < 95) begin
            c.op = OP_PRELOAD;
        end else begin
            c.op = OP_NONE;
        end
        return c;
    endfunction

    task automatic send_cmd(input t_filter_cmd c, input logic typed,
                            input t_filter_resp typed_resp);
        t_filter_resp r;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_opcode     <= c.op;
        i_vlan_id    <= c.vid;
        i_slot_index <= c.slot;
        i_entry_word <= c.word;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (apply_table_op(c, r)) begin
            pending_resp_q.push_back(typed ? typed_resp : r);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_resp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_NUM_ENTRIES) begin
            cfg_num = data;
        end else begin
            cfg_route = data[CHAN_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold off the result side for a long stretch on request, else stall at random
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_filter_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_resp_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected result beat: status %0d slot %0d removed %0d",
                             o_status, o_slot_used, o_removed_count);
                end
            end else begin
                want = pending_resp_q.pop_front();
                if (o_status !== want.status || o_slot_used !== want.slot ||
                    o_removed_count !== want.removed) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("result mismatch: expected status %0d slot %0d removed %0d, %s",
                                 want.status, want.slot, want.removed, "got");
                        $display("    status %0d slot %0d removed %0d",
                                 o_status, o_slot_used, o_removed_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_dir_row    dir_tab [$];
        t_filter_cmd c;
        int          sent;
        foreach (filt_tbl[i]) begin
            filt_tbl[i] = '0;
            own_tbl[i]  = '0;
        end

        dir_tab.push_back(cmd_row(OP_ADD, 16'd0, 5'd0, 32'h0, 1'b1, ST_BAD_ID));
        dir_tab.push_back(cmd_row(OP_ADD, 16'd4096, 5'd31, 32'hFFFF_FFFF, 1'b1, ST_BAD_ID));
        dir_tab.push_back(cmd_row(OP_ADD, 16'hFFFF, 5'd0, 32'h0, 1'b1, ST_BAD_ID));
        dir_tab.push_back(cmd_row(OP_ADD, 16'd1, 5'd0, 32'h0, 1'b1, ST_ADDED, 5'd31));
        dir_tab.push_back(cmd_row(OP_ADD, 16'd1, 5'd0, 32'h0, 1'b1, ST_PRESENT));
        dir_tab.push_back(cmd_row(OP_ADD, 16'd4095, 5'd0, 32'h0, 1'b1, ST_ADDED, 5'd30));
        dir_tab.push_back(cmd_row(OP_PRELOAD, 16'd0, 5'd31, 32'hFFFF_FFFF, 1'b1,
                                  ST_PRELOADED, 5'd31));
        dir_tab.push_back(cmd_row(OP_PRELOAD, 16'hFFFF, 5'd0, 32'h0, 1'b1, ST_PRELOADED));
        dir_tab.push_back(cmd_row(OP_NONE, 16'hFFFF, 5'd31, 32'hFFFF_FFFF));
        dir_tab.push_back(cmd_row(OP_DEL, 16'hFFFF, 5'd0, 32'h0, 1'b1, ST_DELETED));
        dir_tab.push_back(cmd_row(OP_DEL, 16'd0, 5'd0, 32'h0, 1'b1, ST_DELETED));
        dir_tab.push_back(cmd_row(OP_DEL, 16'd4095, 5'd0, 32'h0, 1'b1, ST_DELETED, 5'd0, 6'd1));
        dir_tab.push_back(cmd_row(OP_PRELOAD, 16'd0, 5'd5,
                                  vlan_word(16'h123, ROUTE_CHANNEL_RST)));
        dir_tab.push_back(cmd_row(OP_ADD, 16'h123, 5'd0, 32'h0));
        dir_tab.push_back(cmd_row(OP_ADD, 16'h124, 5'd0, 32'h0));
        dir_tab.push_back(cmd_row(OP_DEL, 16'h123, 5'd0, 32'h0));
        dir_tab.push_back(cfg_row(CFG_ROUTE_CHANNEL, 6'd7));
        dir_tab.push_back(cfg_row(CFG_NUM_ENTRIES, 6'd1));
        dir_tab.push_back(cmd_row(OP_ADD, 16'd5, 5'd0, 32'h0, 1'b1, ST_ADDED, 5'd0));
        dir_tab.push_back(cmd_row(OP_ADD, 16'd6, 5'd0, 32'h0, 1'b1, ST_FULL));
        dir_tab.push_back(cmd_row(OP_PRELOAD, 16'd0, 5'd1, 32'h0, 1'b1, ST_BAD_SLOT));
        dir_tab.push_back(cmd_row(OP_DEL, 16'd5, 5'd0, 32'h0, 1'b1, ST_DELETED, 5'd0, 6'd1));
        dir_tab.push_back(cfg_row(CFG_NUM_ENTRIES, 6'd0));
        dir_tab.push_back(cmd_row(OP_ADD, 16'd7, 5'd0, 32'h0, 1'b1, ST_FULL));
        dir_tab.push_back(cmd_row(OP_DEL, 16'h124, 5'd0, 32'h0, 1'b1, ST_DELETED));
        dir_tab.push_back(cmd_row(OP_PRELOAD, 16'd0, 5'd0, 32'h0, 1'b1, ST_BAD_SLOT));
        dir_tab.push_back(cfg_row(CFG_NUM_ENTRIES, 6'd63));
        dir_tab.push_back(cfg_row(CFG_ROUTE_CHANNEL, 6'h38));
        dir_tab.push_back(cmd_row(OP_PRELOAD, 16'd0, 5'd31, 32'h5A5A_A5A5, 1'b1,
                                  ST_PRELOADED, 5'd31));
        dir_tab.push_back(cmd_row(OP_DEL, 16'h124, 5'd0, 32'h0));
        dir_tab.push_back(cmd_row(OP_ADD, 16'h124, 5'd0, 32'h0));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_data);
            end else begin
                send_cmd(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].resp);
            end
        end

        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 2; k++) begin
                write_reg(CFG_NUM_ENTRIES, PHASE_NUM[2*m+k]);
                write_reg(CFG_ROUTE_CHANNEL, {3'($urandom), PHASE_ROUTE[2*m+k]});
                idle_pct  = IDLE_PCT[m];
                stall_pct = STALL_PCT[m];
                pool_len  = $urandom_range(POOL_MAX, 4);
                foreach (vid_pool[i]) begin
                    vid_pool[i] = VID_W'($urandom_range(ID_MAX, 1));
                end
                vid_pool[0] = 16'd1;
                vid_pool[1] = ID_MAX;
                // hold the result side while beats keep coming
                if (m == 0 && k == 1) begin
                    @(posedge i_clk);
                    hold_req = 1'b1;
                    @(negedge i_clk);
                end
                sent = 0;
                while (sent < ITEMS_PER_PHASE) begin
                    c = draw_cmd();
                    send_cmd(c, 1'b0, '0);
                    if (c.op != OP_NONE) begin
                        sent++;
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_resp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_resp_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
